// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the rtl top level; compiled out with
// NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// ===== rtl/jfs_pkg.sv =====
// ---------------------------------------------------------------------------
// jfs_pkg
// types and constants shared by the jpeg frame size scanner modules
// ---------------------------------------------------------------------------
package jfs_pkg;

    // width of the latched file length
    localparam int LENGTH_BITS = 32;

    // status codes
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_TRUNCATED   = 3'd2;
    localparam logic [2:0] ST_BAD_SEG     = 3'd3;
    localparam logic [2:0] ST_BAD_FRAME   = 3'd4;
    localparam logic [2:0] ST_ZERO_DIM    = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd6;

    // byte classes worked out in the front end
    typedef struct packed {
        logic is_ff;
        logic is_soi;
        logic is_stop;
        logic is_standalone;
        logic is_frame;
    } byte_class_t;

    // one classified byte waiting for the parser
    typedef struct packed {
        logic [7:0]             data_byte;
        logic [LENGTH_BITS-1:0] file_length;
        byte_class_t            cls;
    } item_t;

    // one status transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] width;
        logic [15:0] height;
    } result_t;

endpackage

// ===== rtl/jfs_front.sv =====
// ---------------------------------------------------------------------------
// jfs_front
// accepts file bytes, classifies them as markers and holds them in a
// two-entry queue for the parser
// ---------------------------------------------------------------------------
module jfs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        image_size,
    output logic               item_valid,
    output jfs_pkg::item_t     item,
    input  logic               item_take
);

    localparam logic [7:0] MK_FF   = 8'hff;
    localparam logic [7:0] MK_SOI  = 8'hd8;
    localparam logic [7:0] MK_EOI  = 8'hd9;
    localparam logic [7:0] MK_SOS  = 8'hda;
    localparam logic [7:0] MK_RST0 = 8'hd0;
    localparam logic [7:0] MK_RST7 = 8'hd7;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_NUL  = 8'h00;
    localparam logic [7:0] MK_SOF0 = 8'hc0;
    localparam logic [7:0] MK_SOF15 = 8'hcf;

    jfs_pkg::item_t  q_reg [2];
    jfs_pkg::item_t  new_item;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;

    // byte classification
    always_comb
    begin
        new_item.data_byte   = data_byte;
        new_item.file_length = image_size[jfs_pkg::LENGTH_BITS-1:0];
        new_item.cls.is_ff   = (data_byte == MK_FF);
        new_item.cls.is_soi  = (data_byte == MK_SOI);
        new_item.cls.is_stop = (data_byte == MK_EOI) || (data_byte == MK_SOS);
        new_item.cls.is_standalone = (data_byte == MK_NUL) || (data_byte == MK_TEM)
            || (data_byte == MK_SOI)
            || ((data_byte >= MK_RST0) && (data_byte <= MK_RST7));
        // c4, c8 and cc are not frame markers
        new_item.cls.is_frame = (data_byte >= MK_SOF0) && (data_byte <= MK_SOF15)
            && !((data_byte[1:0] == 2'b00) && (data_byte[3:2] != 2'b00));
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !item_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && item_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (item_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/jfs_parser.sv =====
// ---------------------------------------------------------------------------
// jfs_parser
// marker parser: walks the segments of one file a byte per cycle unless
// the result queue is full; exactly one status transaction per file
// ---------------------------------------------------------------------------
module jfs_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  jfs_pkg::item_t      item,
    input  logic                res_full,
    output logic                item_take,
    output logic                res_push,
    output jfs_pkg::result_t    res
);

    typedef enum logic [12:0] {
        PH_IDLE   = 13'b0000000000001,
        PH_MAGIC2 = 13'b0000000000010,
        PH_SEEK   = 13'b0000000000100,
        PH_FILL   = 13'b0000000001000,
        PH_LEN_HI = 13'b0000000010000,
        PH_LEN_LO = 13'b0000000100000,
        PH_SKIP   = 13'b0000001000000,
        PH_PREC   = 13'b0000010000000,
        PH_H_HI   = 13'b0000100000000,
        PH_H_LO   = 13'b0001000000000,
        PH_W_HI   = 13'b0010000000000,
        PH_W_LO   = 13'b0100000000000,
        PH_DONE   = 13'b1000000000000
    } phase_t;

    localparam int LW = jfs_pkg::LENGTH_BITS;

    phase_t          phase_reg,    phase_next;
    logic [LW-1:0]   rem_reg,      rem_next;
    logic            frame_reg,    frame_next;
    logic [7:0]      seg_hi_reg,   seg_hi_next;
    logic [15:0]     skip_reg,     skip_next;
    logic [15:0]     height_reg,   height_next;
    logic [7:0]      width_hi_reg, width_hi_next;

    logic            last;
    logic            st_valid;
    logic [2:0]      st_code;
    logic [15:0]     w_out;
    logic [15:0]     h_out;
    logic [15:0]     seg_len;
    logic [15:0]     skip_dec;
    logic [15:0]     width_full;
    logic [LW:0]     left_plus2;
    logic [LW:0]     seg_len_ext;

    assign item_take = item_valid && !res_full;

    // bytes still to come after this one; last byte of the file
    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            last     = (item.file_length <= LW'(1));
            rem_next = item.file_length - LW'(2);
        end
        else
        begin
            last     = (rem_reg == '0);
            rem_next = rem_reg - LW'(1);
        end
    end

    assign seg_len     = {seg_hi_reg, item.data_byte};
    assign seg_len_ext = {{(LW+1-16){1'b0}}, seg_len};
    assign left_plus2  = {1'b0, rem_reg} + (LW+1)'(2);
    assign skip_dec    = skip_reg - 16'd1;
    assign width_full  = {width_hi_reg, item.data_byte};

    // segment walk
    always_comb
    begin
        phase_next    = phase_reg;
        frame_next    = frame_reg;
        seg_hi_next   = seg_hi_reg;
        skip_next     = skip_reg;
        height_next   = height_reg;
        width_hi_next = width_hi_reg;
        st_valid      = 1'b0;
        st_code       = jfs_pkg::ST_FOUND;
        w_out         = 16'd0;
        h_out         = 16'd0;

        case (phase_reg)
            PH_IDLE:
            begin
                if ((item.file_length < LW'(4)) || !item.cls.is_ff)
                begin
                    st_valid = 1'b1;
                    st_code  = jfs_pkg::ST_BAD_MAGIC;
                end
                else
                begin
                    phase_next = PH_MAGIC2;
                end
            end
            PH_MAGIC2:
            begin
                if (!item.cls.is_soi)
                begin
                    st_valid = 1'b1;
                    st_code  = jfs_pkg::ST_BAD_MAGIC;
                end
                else
                begin
                    phase_next = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (item.cls.is_ff)
                begin
                    phase_next = PH_FILL;
                end
            end
            PH_FILL:
            begin
                if (!item.cls.is_ff)
                begin
                    frame_next = item.cls.is_frame;
                    if (item.cls.is_stop)
                    begin
                        st_valid = 1'b1;
                        st_code  = jfs_pkg::ST_NOT_FOUND;
                    end
                    else if (item.cls.is_standalone)
                    begin
                        phase_next = PH_SEEK;
                    end
                    else if (rem_reg < LW'(2))
                    begin
                        st_valid = 1'b1;
                        st_code  = jfs_pkg::ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                seg_hi_next = item.data_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if ((seg_len < 16'd2) || (seg_len_ext > left_plus2))
                begin
                    st_valid = 1'b1;
                    st_code  = jfs_pkg::ST_BAD_SEG;
                end
                else if (frame_reg)
                begin
                    if (seg_len < 16'd7)
                    begin
                        st_valid = 1'b1;
                        st_code  = jfs_pkg::ST_BAD_FRAME;
                    end
                    else
                    begin
                        phase_next = PH_PREC;
                    end
                end
                else if (seg_len == 16'd2)
                begin
                    phase_next = PH_SEEK;
                end
                else
                begin
                    skip_next  = seg_len - 16'd2;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_SEEK;
                end
            end
            PH_PREC:
            begin
                phase_next = PH_H_HI;
            end
            PH_H_HI:
            begin
                height_next = {item.data_byte, 8'd0};
                phase_next  = PH_H_LO;
            end
            PH_H_LO:
            begin
                height_next = {height_reg[15:8], item.data_byte};
                phase_next  = PH_W_HI;
            end
            PH_W_HI:
            begin
                width_hi_next = item.data_byte;
                phase_next    = PH_W_LO;
            end
            PH_W_LO:
            begin
                st_valid = 1'b1;
                if ((width_full == 16'd0) || (height_reg == 16'd0))
                begin
                    st_code = jfs_pkg::ST_ZERO_DIM;
                end
                else
                begin
                    st_code = jfs_pkg::ST_FOUND;
                    w_out   = width_full;
                    h_out   = height_reg;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // file ran out without any status
        if (!st_valid && (phase_reg != PH_DONE) && last)
        begin
            st_valid = 1'b1;
            st_code  = jfs_pkg::ST_NOT_FOUND;
        end

        if (st_valid)
        begin
            phase_next = PH_DONE;
        end
        if (last)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign res_push   = item_take && st_valid;
    assign res.status = st_code;
    assign res.width  = w_out;
    assign res.height = h_out;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            rem_reg      <= '0;
            frame_reg    <= 1'b0;
            seg_hi_reg   <= 8'd0;
            skip_reg     <= 16'd0;
            height_reg   <= 16'd0;
            width_hi_reg <= 8'd0;
        end
        else if (item_take)
        begin
            phase_reg    <= phase_next;
            rem_reg      <= rem_next;
            frame_reg    <= frame_next;
            seg_hi_reg   <= seg_hi_next;
            skip_reg     <= skip_next;
            height_reg   <= height_next;
            width_hi_reg <= width_hi_next;
        end
    end

endmodule

// ===== rtl/jfs_result_queue.sv =====
// ---------------------------------------------------------------------------
// jfs_result_queue
// two-entry queue holding status transactions until they are popped
// ---------------------------------------------------------------------------
module jfs_result_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_push,
    input  jfs_pkg::result_t   res,
    output logic               res_full,
    input  logic               pop,
    output logic               empty,
    output jfs_pkg::result_t   head
);

    jfs_pkg::result_t  q_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign head     = q_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (res_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!res_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/jpeg_frame_size_scanner.sv =====
// ---------------------------------------------------------------------------
// jpeg_frame_size_scanner
// scans the bytes of a jpeg file for the first start-of-frame segment and
// reports one status transaction per file with the frame size
// ---------------------------------------------------------------------------
//
//  channel   handshake      payload
//  -------   ------------   ---------------------------------
//  input     push / full    data_byte[7:0], image_size[31:0]
//  result    pop / empty    status[2:0], width[15:0], height[15:0]
//
//  one byte per cycle sustained while the result queue has room; the parser
//  takes one queued byte per cycle and queues each status with its byte
//  the front queue and the result queue hold two entries each, so input
//  keeps flowing while a status transaction waits to be popped
//  reset is asynchronous and clears both queues and the parser state
//  with the result queue full the parser stalls and the front queue fills
//
`include "assert_macros.svh"

module jpeg_frame_size_scanner
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   data_byte,
    input  logic [31:0]  image_size,
    output logic         empty,
    input  logic         pop,
    output logic [2:0]   status,
    output logic [15:0]  width,
    output logic [15:0]  height
);

    logic               item_valid;
    jfs_pkg::item_t     item;
    logic               item_take;
    logic               res_push;
    logic               res_full;
    jfs_pkg::result_t   res;
    jfs_pkg::result_t   head;

    // byte intake and classification
    jfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .image_size (image_size),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // segment parser
    jfs_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .res_full   (res_full),
        .item_take  (item_take),
        .res_push   (res_push),
        .res        (res)
    );

    // status transaction queue
    jfs_result_queue u_result_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    assign status = head.status;
    assign width  = head.width;
    assign height = head.height;

    // checks on the parser to queue hand-off
    `ASSERT_CLK_RST(a_no_res_overflow, clk, rst_n, !(res_push && res_full), "result queue overflow")
    `ASSERT_CLK_RST(a_res_needs_byte, clk, rst_n, res_push |-> item_take, "status without a byte")
    `ASSERT_CLK_RST(a_res_visible, clk, rst_n, res_push |=> !empty, "status transaction lost")
    `ASSERT_CLK_RST(a_take_needs_item, clk, rst_n, item_take |-> item_valid, "parser took from empty queue")

endmodule

// ===== verif/tb_jpeg_frame_size_scanner.sv =====
// ---------------------------------------------------------------------------
// tb_jpeg_frame_size_scanner
// self-checking bench for the jpeg frame size scanner: a short table of
// directed files, then random files, mostly well formed with random
// segments and payload, plus broken headers and wrong file lengths. every
// accepted byte goes through a byte-level scan model and each status
// transaction is checked against the oldest expected report
// ---------------------------------------------------------------------------
module tb_jpeg_frame_size_scanner;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 31;
    localparam int RANDOM_BYTES   = 600;

    // marker bytes
    localparam logic [7:0] MK_FILL = 8'hff;
    localparam logic [7:0] MK_SOI  = 8'hd8;
    localparam logic [7:0] MK_EOI  = 8'hd9;
    localparam logic [7:0] MK_SOS  = 8'hda;
    localparam logic [7:0] MK_RST0 = 8'hd0;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_NULL = 8'h00;
    localparam logic [7:0] MK_SOF0 = 8'hc0;

    typedef enum logic [3:0] {
        SC_IDLE, SC_MAGIC2, SC_SEEK, SC_FILL, SC_LEN_HI, SC_LEN_LO, SC_SKIP,
        SC_PREC, SC_H_HI, SC_H_LO, SC_W_HI, SC_W_LO, SC_DONE
    } scan_phase_t;

    // one row of the directed table; typed rows carry their own report
    typedef struct packed {
        logic [7:0]        d;
        logic [31:0]       sz;
        logic              typed;
        jfs_pkg::result_t  res;
    } dir_row_t;

    // one byte of a generated file
    typedef struct packed {
        logic [7:0]  d;
        logic        start;
        logic [31:0] sz;
    } file_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic [31:0] image_size;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;

    jpeg_frame_size_scanner dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .image_size (image_size),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .width      (width),
        .height     (height)
    );

    // scan model state
    scan_phase_t sc_phase    = SC_IDLE;
    logic [32:0] sc_pos      = '0;
    logic [32:0] sc_len      = '0;
    logic [7:0]  sc_marker   = '0;
    logic [15:0] sc_seg      = '0;
    logic [15:0] sc_skip     = '0;
    logic [15:0] sc_height   = '0;
    logic [7:0]  sc_width_hi = '0;
    logic        sc_reported = 1'b0;

    jfs_pkg::result_t  pending_reports[$];
    file_byte_t        file_bytes[$];
    logic              row_typed;
    jfs_pkg::result_t  row_report;
    logic              in_random;
    logic              calm;
    int                sent_bytes   = 0;
    int                fails        = 0;
    int                quiet_cycles = 0;

    // directed files: short, zero length, bad magic with ignored tail,
    // scan marker, length marker near the end, end of file, extreme size
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{8'hff, 32'd1,         1'b1, '{jfs_pkg::ST_BAD_MAGIC, 16'd0, 16'd0}},
        '{8'h00, 32'd0,         1'b1, '{jfs_pkg::ST_BAD_MAGIC, 16'd0, 16'd0}},
        '{8'hff, 32'd4,         1'b0, '0},
        '{8'h12, 32'hffffffff,  1'b1, '{jfs_pkg::ST_BAD_MAGIC, 16'd0, 16'd0}},
        '{8'hff, 32'h00000000,  1'b0, '0},
        '{8'hd8, 32'h55555555,  1'b0, '0},
        '{8'hff, 32'd4,         1'b0, '0},
        '{8'hd8, 32'haaaaaaaa,  1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hda, 32'hffffffff,  1'b0, '0},
        '{8'hff, 32'd5,         1'b0, '0},
        '{8'hd8, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hc4, 32'h0,         1'b0, '0},
        '{8'h00, 32'h80000000,  1'b0, '0},
        '{8'hff, 32'd5,         1'b0, '0},
        '{8'hd8, 32'h0,         1'b0, '0},
        '{8'h00, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hff, 32'd11,        1'b0, '0},
        '{8'hd8, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hc0, 32'h0,         1'b0, '0},
        '{8'h00, 32'h0,         1'b0, '0},
        '{8'h07, 32'h0,         1'b0, '0},
        '{8'h08, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b0, '0},
        '{8'hff, 32'h0,         1'b1, '{jfs_pkg::ST_FOUND, 16'hffff, 16'hffff}}
    };

    function automatic logic is_frame(input logic [7:0] m);
        return m[7:4] == 4'hc && m[1:0] != 2'b00 || m == MK_SOF0;
    endfunction

    function automatic logic is_standalone(input logic [7:0] m);
        return m == MK_NULL || m == MK_TEM || m == MK_SOI || m[7:3] == MK_RST0[7:3];
    endfunction

    // one byte through the scan model; returns 1 when it ends in a report
    function automatic logic scan_byte(input logic [7:0] d, input logic [31:0] sz,
                                       output jfs_pkg::result_t r);
        logic [32:0] left;
        logic [15:0] w;
        logic        hit;
        hit = 1'b0;
        r   = '0;
        if (sc_phase == SC_IDLE)
        begin
            sc_len      = {1'b0, sz};
            sc_pos      = '0;
            sc_reported = 1'b0;
            if (sc_len < 4 || d != MK_FILL)
            begin
                hit = 1'b1;
                r.status = jfs_pkg::ST_BAD_MAGIC;
            end
            else
                sc_phase = SC_MAGIC2;
        end
        else
        begin
            left = sc_len - sc_pos - 33'd1;
            case (sc_phase)
                SC_MAGIC2:
                    if (d != MK_SOI)
                    begin
                        hit = 1'b1;
                        r.status = jfs_pkg::ST_BAD_MAGIC;
                    end
                    else
                        sc_phase = SC_SEEK;
                SC_SEEK:
                    if (d == MK_FILL)
                        sc_phase = SC_FILL;
                SC_FILL:
                    if (d != MK_FILL)
                    begin
                        sc_marker = d;
                        if (d == MK_EOI || d == MK_SOS)
                        begin
                            hit = 1'b1;
                            r.status = jfs_pkg::ST_NOT_FOUND;
                        end
                        else if (is_standalone(d))
                            sc_phase = SC_SEEK;
                        else if (left < 2)
                        begin
                            hit = 1'b1;
                            r.status = jfs_pkg::ST_TRUNCATED;
                        end
                        else
                            sc_phase = SC_LEN_HI;
                    end
                SC_LEN_HI:
                begin
                    sc_seg   = {d, 8'h00};
                    sc_phase = SC_LEN_LO;
                end
                SC_LEN_LO:
                begin
                    sc_seg[7:0] = d;
                    if (sc_seg < 2 || sc_seg > left + 33'd2)
                    begin
                        hit = 1'b1;
                        r.status = jfs_pkg::ST_BAD_SEG;
                    end
                    else if (is_frame(sc_marker))
                    begin
                        if (sc_seg < 7)
                        begin
                            hit = 1'b1;
                            r.status = jfs_pkg::ST_BAD_FRAME;
                        end
                        else
                            sc_phase = SC_PREC;
                    end
                    else if (sc_seg == 2)
                        sc_phase = SC_SEEK;
                    else
                    begin
                        sc_skip  = sc_seg - 16'd2;
                        sc_phase = SC_SKIP;
                    end
                end
                SC_SKIP:
                begin
                    sc_skip = sc_skip - 16'd1;
                    if (sc_skip == 0)
                        sc_phase = SC_SEEK;
                end
                SC_PREC:
                    sc_phase = SC_H_HI;
                SC_H_HI:
                begin
                    sc_height[15:8] = d;
                    sc_phase        = SC_H_LO;
                end
                SC_H_LO:
                begin
                    sc_height[7:0] = d;
                    sc_phase       = SC_W_HI;
                end
                SC_W_HI:
                begin
                    sc_width_hi = d;
                    sc_phase    = SC_W_LO;
                end
                SC_W_LO:
                begin
                    w   = {sc_width_hi, d};
                    hit = 1'b1;
                    if (w == 0 || sc_height == 0)
                        r.status = jfs_pkg::ST_ZERO_DIM;
                    else
                    begin
                        r.status = jfs_pkg::ST_FOUND;
                        r.width  = w;
                        r.height = sc_height;
                    end
                end
                default: ;
            endcase
        end

        // last byte of the file with nothing reported yet
        if (!hit && !sc_reported && sc_pos + 33'd1 >= sc_len)
        begin
            hit = 1'b1;
            r.status = jfs_pkg::ST_NOT_FOUND;
        end
        if (hit)
        begin
            sc_reported = 1'b1;
            sc_phase    = SC_DONE;
        end

        // rearm after the last byte
        if (sc_pos + 33'd1 >= sc_len)
        begin
            sc_phase    = SC_IDLE;
            sc_reported = 1'b0;
            sc_pos      = '0;
        end
        else
            sc_pos = sc_pos + 33'd1;
        return hit;
    endfunction

    // random file into the byte queue, mostly well formed
    task automatic make_file();
        logic [7:0]  f[$];
        logic [7:0]  mk;
        logic [15:0] seg;
        logic [15:0] hh;
        logic [15:0] ww;
        int          pick;
        int          decl;
        int          k;
        file_byte_t  fb;
        f = {MK_FILL, MK_SOI};
        if ($urandom_range(99) < 4)
            f[$urandom_range(1, 0)] = 8'($urandom);

        // leading segments: junk, fill bytes, standalone markers, skipped segments
        repeat ($urandom_range(3, 0))
        begin
            repeat ($urandom_range(2, 0))
                f.push_back(8'($urandom_range(254, 0)));
            repeat ($urandom_range(2, 1))
                f.push_back(MK_FILL);
            if ($urandom_range(3) == 0)
            begin
                pick = $urandom_range(10, 0);
                if (pick < 8)
                    f.push_back(MK_RST0 + 8'(pick));
                else if (pick == 8)
                    f.push_back(MK_NULL);
                else if (pick == 9)
                    f.push_back(MK_TEM);
                else
                    f.push_back(MK_SOI);
            end
            else
            begin
                do
                    mk = 8'($urandom);
                while (is_frame(mk) || is_standalone(mk) || mk == MK_FILL ||
                       mk == MK_EOI || mk == MK_SOS);
                seg = 16'($urandom_range(8, 2));
                f.push_back(mk);
                f.push_back(seg[15:8]);
                f.push_back(seg[7:0]);
                repeat (seg - 2)
                    f.push_back(8'($urandom));
            end
        end

        // how the file ends
        pick = $urandom_range(99);
        if (pick < 76)
        begin
            do
                mk = MK_SOF0 + 8'($urandom_range(15, 0));
            while (!is_frame(mk));
            f.push_back(MK_FILL);
            f.push_back(mk);
            if (pick < 60)
                seg = 16'($urandom_range(17, 7));
            else if (pick < 68)
                seg = 16'($urandom_range(6, 0));
            else
                seg = 16'($urandom_range(65535, 200));
            f.push_back(seg[15:8]);
            f.push_back(seg[7:0]);
            hh = 16'($urandom);
            ww = 16'($urandom);
            k  = $urandom_range(9);
            if (k == 0)
                hh = '0;
            else if (k == 1)
                ww = '0;
            if (pick < 60)
            begin
                f.push_back(8'h08);
                f.push_back(hh[15:8]);
                f.push_back(hh[7:0]);
                f.push_back(ww[15:8]);
                f.push_back(ww[7:0]);
                repeat (seg - 7)
                    f.push_back(8'($urandom));
            end
        end
        else if (pick < 86)
        begin
            f.push_back(MK_FILL);
            f.push_back($urandom_range(1) ? MK_EOI : MK_SOS);
        end
        else if (pick < 94)
            f.push_back(8'($urandom_range(254, 0)));
        else
        begin
            do
                mk = 8'($urandom);
            while (is_standalone(mk) || mk == MK_FILL || mk == MK_EOI || mk == MK_SOS);
            f.push_back(MK_FILL);
            f.push_back(mk);
            if ($urandom_range(1))
                f.push_back(8'($urandom));
        end

        // trailing bytes, ignored once the report is out
        if (pick < 94)
            repeat ($urandom_range(4, 0))
                f.push_back(8'($urandom));

        decl = f.size();
        if ($urandom_range(99) < 10)
            decl = $urandom_range(f.size() + 6, 0);
        foreach (f[i])
        begin
            fb.d     = f[i];
            fb.start = (i == 0);
            fb.sz    = 32'(decl);
            file_bytes.push_back(fb);
        end
    endtask

    // offer one byte and hold it until the scanner takes it
    task automatic put_byte(input logic [7:0] d, input logic [31:0] sz);
        while (!calm && $urandom_range(99) < 17)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push       = 1'b1;
        data_byte  = d;
        image_size = sz;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random pop
    always @(negedge clk)
    begin
        pop = rst_n && (calm || $urandom_range(99) >= 17);
    end

    // accepted bytes feed the scan model, accepted transactions are checked
    always @(posedge clk)
    begin : monitor
        jfs_pkg::result_t want;
        logic             hit;
        if (rst_n)
        begin
            if (push && !full)
            begin
                hit = scan_byte(data_byte, image_size, want);
                if (row_typed)
                begin
                    hit  = 1'b1;
                    want = row_report;
                end
                if (hit)
                    pending_reports.push_back(want);
                if (in_random)
                    sent_bytes++;
            end
            if (pop && !empty)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("status transaction with none expected: status %0d", status);
                    fails++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                    if (width !== want.width)
                    begin
                        $error("width mismatch: expected %0d, got %0d", want.width, width);
                        fails++;
                    end
                    if (height !== want.height)
                    begin
                        $error("height mismatch: expected %0d, got %0d", want.height, height);
                        fails++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** jpeg_frame_size_scanner: FAILED **");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        file_byte_t  fb;
        logic [31:0] sz;
        rst_n      = 1'b0;
        push       = 1'b0;
        data_byte  = '0;
        image_size = '0;
        row_typed  = 1'b0;
        row_report = '0;
        in_random  = 1'b0;
        calm       = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_typed  = dir_tab[i].typed;
            row_report = dir_tab[i].res;
            put_byte(dir_tab[i].d, dir_tab[i].sz);
        end
        row_typed = 1'b0;

        // random files; file length only matters on the first byte of a file
        in_random = 1'b1;
        while (sent_bytes < RANDOM_BYTES)
        begin
            make_file();
            while (file_bytes.size() != 0)
            begin
                fb   = file_bytes.pop_front();
                calm = sent_bytes >= 200 && sent_bytes < 350;
                if (sc_phase != SC_IDLE)
                    sz = $urandom;
                else if (fb.start)
                    sz = fb.sz;
                else
                    sz = $urandom_range(40, 0);
                put_byte(fb.d, sz);
            end
        end
        push = 1'b0;
        calm = 1'b0;

        // drain, then a short tail for stray transactions
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (fails == 0)
            $display("** jpeg_frame_size_scanner: PASSED **");
        else
            $display("** jpeg_frame_size_scanner: FAILED **");
        $finish;
    end

endmodule
